// File: src/delta_packed_offset_table_assert.svh
// assertion macros for the delta packed offset table
`ifndef DELTA_PACKED_OFFSET_TABLE_ASSERT_SVH
`define DELTA_PACKED_OFFSET_TABLE_ASSERT_SVH
// concurrent check, disabled while reset is asserted
`define DPOT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// concurrent check that also holds during reset
`define DPOT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: src/dpot_pkg.sv
// shared types, codes and field helpers for the delta packed offset table
`timescale 1ns / 1ps
package dpot_pkg;

    localparam logic [9:0] MASK_WIDE   = 10'h3ff;
    localparam logic [9:0] MASK_NARROW = 10'h0ff;
    localparam logic [9:0] BIAS_WIDE   = 10'd511;
    localparam logic [9:0] BIAS_NARROW = 10'd127;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_SPILL_FULL = 2'd2,
        ST_RANGE      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_KEYS  = 2'd0,
        REG_BPK   = 2'd1,
        REG_BPB   = 2'd2,
        REG_LIMIT = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ALU_ADD3 = 2'd0,
        ALU_ABS  = 2'd1,
        ALU_MUL  = 2'd2
    } alu_op_t;

    typedef struct packed {
        alu_op_t     op;
        logic        neg_b;
        logic        neg_c;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } alu_req_t;

    typedef struct packed {
        logic [15:0] dest_stride;
        logic [15:0] bits_per_key_q8;
        logic [23:0] bits_per_bucket;
        logic [12:0] entry_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0] word;
        logic [4:0] shift;
        logic       wide;
    } fld_loc_t;

    // word offset and bit place of a non-head entry inside its group
    function automatic fld_loc_t locate(input logic [3:0] r);
        fld_loc_t   l;
        logic [3:0] rank;
        logic [5:0] slot;
        rank = r - {2'b00, r[3:2]} - 4'd1;
        slot = {4'b0000, r[3:2]} - 6'd1;
        if (r[1:0] == 2'b00)
        begin
            l.word  = 3'd1;
            l.shift = 5'(slot * 6'd10);
            l.wide  = 1'b1;
        end
        else
        begin
            l.word  = 3'd2 + {1'b0, rank[3:2]};
            l.shift = {rank[1:0], 3'b000};
            l.wide  = 1'b0;
        end
        return l;
    endfunction

    function automatic logic [9:0] get_field(input logic [63:0] w, input logic [5:0] pos,
                                             input logic wide);
        logic [63:0] s;
        s = w >> pos;
        return wide ? s[9:0] : {2'b00, s[7:0]};
    endfunction

    function automatic logic [63:0] put_field(input logic [63:0] w, input logic [5:0] pos,
                                              input logic wide, input logic [9:0] f);
        logic [63:0] m;
        m = wide ? 64'h3ff : 64'h0ff;
        return (w & ~(m << pos)) | (({54'd0, f} & m) << pos);
    endfunction

    // stored field back to a signed 32-bit delta
    function automatic logic [31:0] field_delta(input logic [9:0] f, input logic [9:0] bias);
        logic signed [10:0] t;
        t = $signed({1'b0, f}) - $signed({1'b0, bias});
        return {{21{t[10]}}, t};
    endfunction

endpackage

// File: src/delta_packed_offset_table.sv
// top level: delta packed offset table with stream ports and register port
// append and query run over one shared add/multiply unit and single-port memories
// query walks back link by link to the group head (at most 6 links), reading any
// field held in the spill store; one beat is in work at a time
// reset clears the fill counts, so memories need no clearing pass and the
// block is ready as soon as reset is released; config registers reset too
`timescale 1ns / 1ps
module delta_packed_offset_table
    import dpot_pkg::*;
#(
    parameter int ENTRIES     = 4096,
    parameter int SPILL_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // new_index_offset, new_dest_offset, query_entry, zero pad
    input  logic [0:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // index_offset_out, dest_offset_out, status, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int EW  = $clog2(ENTRIES);
    localparam int WAW = $clog2(ENTRIES / 16 * 5);
    localparam int KW  = EW + 1;
    localparam int SW  = $clog2(SPILL_DEPTH);

    cfg_t           cfg_reg;
    reg_idx_t       reg_sel;
    alu_req_t       alu_req;
    logic [31:0]    alu_res;
    logic [31:0]    out_index;
    logic [31:0]    out_dest;
    logic [1:0]     out_status;
    logic [WAW-1:0] pk_addr;
    logic           pk_we;
    logic [63:0]    pk_wdata;
    logic [63:0]    pk_rdata;
    logic [KW-1:0]  map_addr;
    logic           map_we;
    logic [SW-1:0]  map_wdata;
    logic [SW-1:0]  map_rdata;
    logic [SW-1:0]  val_addr;
    logic           val_we;
    logic [31:0]    val_wdata;
    logic [31:0]    val_rdata;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3:2]);
    assign m_tdata = {6'd0, out_status, out_dest, out_index};

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_stride     <= 16'd0;
            cfg_reg.bits_per_key_q8 <= 16'd0;
            cfg_reg.bits_per_bucket <= 24'd0;
            cfg_reg.entry_limit     <= 13'd4096;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_sel)
                REG_KEYS:  cfg_reg.dest_stride     <= pwdata[15:0];
                REG_BPK:   cfg_reg.bits_per_key_q8 <= pwdata[15:0];
                REG_BPB:   cfg_reg.bits_per_bucket <= pwdata[23:0];
                REG_LIMIT: cfg_reg.entry_limit     <= pwdata[12:0];
                default:   cfg_reg.entry_limit     <= cfg_reg.entry_limit;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (reg_sel)
            REG_KEYS:  prdata = {16'd0, cfg_reg.dest_stride};
            REG_BPK:   prdata = {16'd0, cfg_reg.bits_per_key_q8};
            REG_BPB:   prdata = {8'd0, cfg_reg.bits_per_bucket};
            REG_LIMIT: prdata = {19'd0, cfg_reg.entry_limit};
            default:   prdata = 32'd0;
        endcase
    end

    dpot_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    dpot_store #(
        .ENTRIES     (ENTRIES),
        .SPILL_DEPTH (SPILL_DEPTH)
    ) u_store (
        .clk       (clk),
        .pk_addr   (pk_addr),
        .pk_we     (pk_we),
        .pk_wdata  (pk_wdata),
        .pk_rdata  (pk_rdata),
        .map_addr  (map_addr),
        .map_we    (map_we),
        .map_wdata (map_wdata),
        .map_rdata (map_rdata),
        .val_addr  (val_addr),
        .val_we    (val_we),
        .val_wdata (val_wdata),
        .val_rdata (val_rdata)
    );

    dpot_seq #(
        .ENTRIES     (ENTRIES),
        .SPILL_DEPTH (SPILL_DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser[0]),
        .in_index   (s_tdata[31:0]),
        .in_dest    (s_tdata[63:32]),
        .in_query   (s_tdata[75:64]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_index  (out_index),
        .out_dest   (out_dest),
        .out_status (out_status),
        .alu_req    (alu_req),
        .alu_res    (alu_res),
        .pk_addr    (pk_addr),
        .pk_we      (pk_we),
        .pk_wdata   (pk_wdata),
        .pk_rdata   (pk_rdata),
        .map_addr   (map_addr),
        .map_we     (map_we),
        .map_wdata  (map_wdata),
        .map_rdata  (map_rdata),
        .val_addr   (val_addr),
        .val_we     (val_we),
        .val_wdata  (val_wdata),
        .val_rdata  (val_rdata)
    );

endmodule

// File: src/dpot_alu.sv
// shared arithmetic unit: three-input add, absolute value, q8.8 scaling
`timescale 1ns / 1ps
module dpot_alu
    import dpot_pkg::*;
(
    input  alu_req_t    req,
    output logic [31:0] res
);

    logic [31:0] bx;
    logic [31:0] cx;
    logic [47:0] prod;

    always_comb
    begin
        bx   = req.neg_b ? ~req.b : req.b;
        cx   = req.neg_c ? ~req.c : req.c;
        prod = {16'd0, req.a} * {32'd0, req.b[15:0]};
        case (req.op)
            ALU_ADD3: res = req.a + bx + cx + {31'd0, req.neg_b} + {31'd0, req.neg_c};
            ALU_ABS:  res = req.a[31] ? (~req.a + 32'd1) : req.a;
            ALU_MUL:  res = prod[39:8];
            default:  res = 32'd0;
        endcase
    end

endmodule

// File: src/dpot_store.sv
// packed word memory, spill slot map and spill value memory
`timescale 1ns / 1ps
module dpot_store
    import dpot_pkg::*;
#(
    parameter int ENTRIES     = 4096,
    parameter int SPILL_DEPTH = 64,
    localparam int EW  = $clog2(ENTRIES),
    localparam int WAW = $clog2(ENTRIES / 16 * 5),
    localparam int KW  = EW + 1,
    localparam int SW  = $clog2(SPILL_DEPTH)
)
(
    input  logic           clk,
    input  logic [WAW-1:0] pk_addr,
    input  logic           pk_we,
    input  logic [63:0]    pk_wdata,
    output logic [63:0]    pk_rdata,
    input  logic [KW-1:0]  map_addr,
    input  logic           map_we,
    input  logic [SW-1:0]  map_wdata,
    output logic [SW-1:0]  map_rdata,
    input  logic [SW-1:0]  val_addr,
    input  logic           val_we,
    input  logic [31:0]    val_wdata,
    output logic [31:0]    val_rdata
);

    localparam int WORDS = ENTRIES / 16 * 5;

    logic [63:0]   pk_mem  [WORDS];
    logic [SW-1:0] map_mem [2*ENTRIES];
    logic [31:0]   val_mem [SPILL_DEPTH];

    // packed words, five per group of sixteen entries
    always_ff @(posedge clk)
    begin
        if (pk_we)
        begin
            pk_mem[pk_addr] <= pk_wdata;
        end
        pk_rdata <= pk_mem[pk_addr];
    end

    // key to spill slot map, key is entry*2 plus the dest flag
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_addr] <= map_wdata;
        end
        map_rdata <= map_mem[map_addr];
    end

    // spill values
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_addr] <= val_wdata;
        end
        val_rdata <= val_mem[val_addr];
    end

endmodule

// File: src/dpot_seq.sv
// sequencer: append and query walks over the shared unit and memories
`timescale 1ns / 1ps
module dpot_seq
    import dpot_pkg::*;
#(
    parameter int ENTRIES     = 4096,
    parameter int SPILL_DEPTH = 64,
    localparam int EW  = $clog2(ENTRIES),
    localparam int WAW = $clog2(ENTRIES / 16 * 5),
    localparam int KW  = EW + 1,
    localparam int SW  = $clog2(SPILL_DEPTH)
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           in_mode,
    input  logic [31:0]    in_index,
    input  logic [31:0]    in_dest,
    input  logic [11:0]    in_query,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    out_index,
    output logic [31:0]    out_dest,
    output logic [1:0]     out_status,
    output alu_req_t       alu_req,
    input  logic [31:0]    alu_res,
    output logic [WAW-1:0] pk_addr,
    output logic           pk_we,
    output logic [63:0]    pk_wdata,
    input  logic [63:0]    pk_rdata,
    output logic [KW-1:0]  map_addr,
    output logic           map_we,
    output logic [SW-1:0]  map_wdata,
    input  logic [SW-1:0]  map_rdata,
    output logic [SW-1:0]  val_addr,
    output logic           val_we,
    output logic [31:0]    val_wdata,
    input  logic [31:0]    val_rdata
);

    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int SCW = $clog2(SPILL_DEPTH + 1);
    localparam int LW  = (CW > 14) ? CW : 14;
    localparam int QW  = (CW > 12) ? CW : 12;
    localparam logic [SCW:0] SPILL_MAX = (SCW + 1)'(SPILL_DEPTH);
    localparam logic [LW-1:0] ENTRY_MAX = LW'(ENTRIES / 16 * 16);

    typedef enum logic [4:0] {
        S_IDLE, S_A_HEAD, S_A_DD, S_ABS, S_MUL, S_A_DI, S_A_DI2, S_A_CHK,
        S_A_RD, S_A_WR, S_A_SPI, S_A_SPD, S_A_FIN,
        S_Q_ADDR, S_Q_LATCH, S_Q_HEAD_I, S_Q_HEAD_D, S_Q_DFLD, S_Q_IFLD,
        S_SP_MAP, S_SP_VAL, S_SP_GET, S_Q_ACD, S_Q_ACI, S_Q_ACC, S_OUT
    } state_t;

    state_t         state_reg;
    logic [CW-1:0]  count_reg;
    logic [SCW-1:0] spill_cnt_reg;
    logic           out_valid_reg;

    logic           mode_reg;
    logic [31:0]    ix_reg;
    logic [31:0]    dx_reg;
    logic [EW-1:0]  cur_reg;
    logic [31:0]    acc_i_reg;
    logic [31:0]    acc_d_reg;
    logic [31:0]    dd_reg;
    logic [31:0]    di_reg;
    logic [31:0]    mag_reg;
    logic [31:0]    corr_reg;
    logic           sign_reg;
    logic [63:0]    word_reg;
    logic           sp_dest_reg;
    logic           fit_i_reg;
    logic           fit_d_reg;
    status_t        res_status_reg;
    logic [31:0]    out_ix_reg;
    logic [31:0]    out_dx_reg;
    status_t        out_status_reg;
    logic [31:0]    rec_ix_reg [16];
    logic [31:0]    rec_dx_reg [16];

    logic           accept;
    logic           load_out;
    logic [3:0]     r_cur;
    logic           is_quad;
    fld_loc_t       loc;
    logic [9:0]     mask;
    logic [9:0]     bias;
    logic [5:0]     pos_i;
    logic [5:0]     pos_d;
    logic [3:0]     prev;
    logic [31:0]    nk;
    logic [31:0]    nb;
    logic [WAW-1:0] grp_w;
    logic [WAW-1:0] base_w;
    logic [WAW-1:0] word_addr;
    logic [9:0]     fld_i;
    logic [9:0]     fld_d;
    logic           mark_i;
    logic           mark_d;
    logic [13:0]    lim_sum;
    logic [LW-1:0]  lim_round;
    logic [LW-1:0]  lim;
    logic           table_full;
    logic           out_range;
    logic signed [31:0] bias_s;
    logic           fit_i;
    logic           fit_d;
    logic [1:0]     need;
    logic           spill_ok;
    logic [9:0]     put_i;
    logic [9:0]     put_d;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign load_out  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_index = out_ix_reg;
    assign out_dest  = out_dx_reg;
    assign out_status = out_status_reg;

    // entry place, strides and field views of the current entry
    always_comb
    begin
        r_cur   = cur_reg[3:0];
        is_quad = (r_cur[1:0] == 2'b00);
        loc     = locate(r_cur);
        mask    = loc.wide ? MASK_WIDE : MASK_NARROW;
        bias    = loc.wide ? BIAS_WIDE : BIAS_NARROW;
        pos_i   = {1'b0, loc.shift};
        pos_d   = {1'b1, loc.shift};
        prev    = r_cur - (is_quad ? 4'd4 : 4'd1);
        nk      = is_quad ? {14'd0, cfg.dest_stride, 2'b00} : {16'd0, cfg.dest_stride};
        nb      = is_quad ? {6'd0, cfg.bits_per_bucket, 2'b00} : {8'd0, cfg.bits_per_bucket};
        grp_w   = WAW'(cur_reg >> 4);
        base_w  = (grp_w << 2) + grp_w;
        word_addr = (r_cur == 4'd0) ? base_w : base_w + WAW'(loc.word);
        fld_i   = get_field(word_reg, pos_i, loc.wide);
        fld_d   = get_field(word_reg, pos_d, loc.wide);
        mark_i  = (fld_i == mask);
        mark_d  = (fld_d == mask);
    end

    // usable entries, range checks and spill room
    always_comb
    begin
        lim_sum    = {1'b0, cfg.entry_limit} + 14'd15;
        lim_round  = LW'({lim_sum[13:4], 4'b0000});
        lim        = (lim_round > ENTRY_MAX) ? ENTRY_MAX : lim_round;
        table_full = (LW'(count_reg) >= lim);
        out_range  = (QW'(in_query) >= QW'(count_reg));
        bias_s     = $signed({22'd0, bias});
        fit_i      = ($signed(di_reg) >= -bias_s) && ($signed(di_reg) < bias_s);
        fit_d      = ($signed(dd_reg) >= -bias_s) && ($signed(dd_reg) < bias_s);
        need       = {1'b0, !fit_i} + {1'b0, !fit_d};
        spill_ok   = ({1'b0, spill_cnt_reg} + (SCW + 1)'(need)) <= SPILL_MAX;
        put_i      = fit_i_reg ? (di_reg[9:0] + bias) : mask;
        put_d      = fit_d_reg ? (dd_reg[9:0] + bias) : mask;
    end

    // shared unit requests
    always_comb
    begin
        alu_req = '{op: ALU_ADD3, neg_b: 1'b0, neg_c: 1'b0, a: 32'd0, b: 32'd0, c: 32'd0};
        case (state_reg)
            S_A_DD:
            begin
                alu_req.a = dx_reg;
                alu_req.b = rec_dx_reg[prev];
                alu_req.c = nk;
                alu_req.neg_b = 1'b1;
                alu_req.neg_c = 1'b1;
            end
            S_ABS:
            begin
                alu_req.op = ALU_ABS;
                alu_req.a  = dd_reg;
            end
            S_MUL:
            begin
                alu_req.op = ALU_MUL;
                alu_req.a  = mag_reg;
                alu_req.b  = {16'd0, cfg.bits_per_key_q8};
            end
            S_A_DI:
            begin
                alu_req.a = ix_reg;
                alu_req.b = rec_ix_reg[prev];
                alu_req.c = nb;
                alu_req.neg_b = 1'b1;
                alu_req.neg_c = 1'b1;
            end
            S_A_DI2:
            begin
                alu_req.a = di_reg;
                alu_req.b = corr_reg;
                alu_req.neg_b = !sign_reg;
            end
            S_Q_HEAD_I:
            begin
                alu_req.a = acc_i_reg;
                alu_req.b = word_reg[31:0];
            end
            S_Q_HEAD_D:
            begin
                alu_req.a = acc_d_reg;
                alu_req.b = word_reg[63:32];
            end
            S_Q_ACD:
            begin
                alu_req.a = acc_d_reg;
                alu_req.b = dd_reg;
                alu_req.c = nk;
            end
            S_Q_ACI:
            begin
                alu_req.a = acc_i_reg;
                alu_req.b = di_reg;
                alu_req.c = nb;
            end
            S_Q_ACC:
            begin
                alu_req.a = acc_i_reg;
                alu_req.b = corr_reg;
                alu_req.neg_b = sign_reg;
            end
            default:
            begin
                alu_req.op = ALU_ADD3;
            end
        endcase
    end

    // memory port drive
    always_comb
    begin
        pk_addr   = word_addr;
        pk_we     = 1'b0;
        pk_wdata  = put_field(put_field(pk_rdata, pos_i, loc.wide, put_i), pos_d, loc.wide, put_d);
        map_addr  = {cur_reg, sp_dest_reg};
        map_we    = 1'b0;
        map_wdata = spill_cnt_reg[SW-1:0];
        val_addr  = map_rdata;
        val_we    = 1'b0;
        val_wdata = di_reg;
        case (state_reg)
            S_A_HEAD:
            begin
                pk_we    = 1'b1;
                pk_wdata = {dx_reg, ix_reg};
            end
            S_A_WR:
            begin
                pk_we = 1'b1;
            end
            S_A_SPI:
            begin
                map_addr = {cur_reg, 1'b0};
                map_we   = 1'b1;
                val_addr = spill_cnt_reg[SW-1:0];
                val_we   = 1'b1;
            end
            S_A_SPD:
            begin
                map_addr  = {cur_reg, 1'b1};
                map_we    = 1'b1;
                val_addr  = spill_cnt_reg[SW-1:0];
                val_we    = 1'b1;
                val_wdata = dd_reg;
            end
            default:
            begin
                pk_we = 1'b0;
            end
        endcase
    end

    // state, fill counts and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            spill_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_OUT && load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (!in_mode)
                        begin
                            if (table_full)
                                state_reg <= S_OUT;
                            else if (count_reg[3:0] == 4'd0)
                                state_reg <= S_A_HEAD;
                            else
                                state_reg <= S_A_DD;
                        end
                        else
                        begin
                            state_reg <= out_range ? S_OUT : S_Q_ADDR;
                        end
                    end
                end
                S_A_HEAD:   state_reg <= S_A_FIN;
                S_A_DD:     state_reg <= S_ABS;
                S_ABS:      state_reg <= S_MUL;
                S_MUL:      state_reg <= mode_reg ? S_Q_ACD : S_A_DI;
                S_A_DI:     state_reg <= S_A_DI2;
                S_A_DI2:    state_reg <= S_A_CHK;
                S_A_CHK:    state_reg <= spill_ok ? S_A_RD : S_OUT;
                S_A_RD:     state_reg <= S_A_WR;
                S_A_WR:
                begin
                    if (!fit_i_reg)
                        state_reg <= S_A_SPI;
                    else if (!fit_d_reg)
                        state_reg <= S_A_SPD;
                    else
                        state_reg <= S_A_FIN;
                end
                S_A_SPI:
                begin
                    spill_cnt_reg <= spill_cnt_reg + 1'b1;
                    state_reg     <= fit_d_reg ? S_A_FIN : S_A_SPD;
                end
                S_A_SPD:
                begin
                    spill_cnt_reg <= spill_cnt_reg + 1'b1;
                    state_reg     <= S_A_FIN;
                end
                S_A_FIN:
                begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= S_OUT;
                end
                S_Q_ADDR:   state_reg <= S_Q_LATCH;
                S_Q_LATCH:  state_reg <= (r_cur == 4'd0) ? S_Q_HEAD_I : S_Q_DFLD;
                S_Q_HEAD_I: state_reg <= S_Q_HEAD_D;
                S_Q_HEAD_D: state_reg <= S_OUT;
                S_Q_DFLD:   state_reg <= mark_d ? S_SP_MAP : S_Q_IFLD;
                S_Q_IFLD:   state_reg <= mark_i ? S_SP_MAP : S_ABS;
                S_SP_MAP:   state_reg <= S_SP_VAL;
                S_SP_VAL:   state_reg <= S_SP_GET;
                S_SP_GET:   state_reg <= sp_dest_reg ? S_Q_IFLD : S_ABS;
                S_Q_ACD:    state_reg <= S_Q_ACI;
                S_Q_ACI:    state_reg <= S_Q_ACC;
                S_Q_ACC:    state_reg <= S_Q_ADDR;
                S_OUT:
                begin
                    if (load_out)
                        state_reg <= S_IDLE;
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

    // working registers and result payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_reg  <= in_mode;
                    ix_reg    <= in_index;
                    dx_reg    <= in_dest;
                    cur_reg   <= in_mode ? EW'(in_query) : EW'(count_reg);
                    acc_i_reg <= 32'd0;
                    acc_d_reg <= 32'd0;
                    if (!in_mode)
                        res_status_reg <= table_full ? ST_TABLE_FULL : ST_OK;
                    else
                        res_status_reg <= out_range ? ST_RANGE : ST_OK;
                end
            end
            S_A_DD:     dd_reg <= alu_res;
            S_ABS:
            begin
                mag_reg  <= alu_res;
                sign_reg <= dd_reg[31];
            end
            S_MUL:      corr_reg <= alu_res;
            S_A_DI:     di_reg <= alu_res;
            S_A_DI2:    di_reg <= alu_res;
            S_A_CHK:
            begin
                fit_i_reg <= fit_i;
                fit_d_reg <= fit_d;
                if (!spill_ok)
                    res_status_reg <= ST_SPILL_FULL;
            end
            S_A_FIN:
            begin
                rec_ix_reg[r_cur] <= ix_reg;
                rec_dx_reg[r_cur] <= dx_reg;
            end
            S_Q_LATCH:  word_reg <= pk_rdata;
            S_Q_HEAD_I: acc_i_reg <= alu_res;
            S_Q_HEAD_D: acc_d_reg <= alu_res;
            S_Q_DFLD:
            begin
                sp_dest_reg <= 1'b1;
                if (!mark_d)
                    dd_reg <= field_delta(fld_d, bias);
            end
            S_Q_IFLD:
            begin
                sp_dest_reg <= 1'b0;
                if (!mark_i)
                    di_reg <= field_delta(fld_i, bias);
            end
            S_SP_GET:
            begin
                if (sp_dest_reg)
                    dd_reg <= val_rdata;
                else
                    di_reg <= val_rdata;
            end
            S_Q_ACD:    acc_d_reg <= alu_res;
            S_Q_ACI:    acc_i_reg <= alu_res;
            S_Q_ACC:
            begin
                acc_i_reg <= alu_res;
                cur_reg   <= cur_reg - (is_quad ? EW'(4) : EW'(1));
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    out_ix_reg     <= acc_i_reg;
                    out_dx_reg     <= acc_d_reg;
                    out_status_reg <= res_status_reg;
                end
            end
            default:
            begin
                mode_reg <= mode_reg;
            end
        endcase
    end

endmodule

// File: src/dpot_checker.sv
// port-level checks for the delta packed offset table, bound to the top level
`timescale 1ns / 1ps
`include "delta_packed_offset_table_assert.svh"
module dpot_checker
    import dpot_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // stalled output beat keeps its payload
    `DPOT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output beat changed while stalled")
    // one beat in work at a time
    `DPOT_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "ready right after accept")
    // error results carry zero offsets
    `DPOT_ASSERT(a_err_zero, m_tvalid && m_tdata[65:64] != ST_OK |-> m_tdata[63:0] == 64'd0, "error beat with offsets")
    // no output beat under reset
    `DPOT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !m_tvalid, "output valid during reset")

endmodule

bind delta_packed_offset_table dpot_checker u_dpot_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/tb_delta_packed_offset_table.sv
// testbench for the delta packed offset table: directed table plus random phases
`timescale 1ns / 1ps
module tb_delta_packed_offset_table;
    import dpot_pkg::*;

    localparam int N_ENTRIES  = 4096;
    localparam int N_SPILL    = 64;
    localparam int N_WORDS    = N_ENTRIES / 16 * 5;
    localparam int DRAIN_WAIT = 120;
    localparam int PHASE_BEATS = 205;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // new_index_offset, new_dest_offset, query_entry, zero pad
    logic [0:0]  s_tuser;   // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // index_offset_out, dest_offset_out, status, zero pad
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct {
        logic [31:0] index_off;
        logic [31:0] dest_off;
        status_t     status;
    } offset_result_t;

    typedef struct {
        logic        mode;
        logic [31:0] index_off;
        logic [31:0] dest_off;
        logic [11:0] entry;
        bit          typed;
        logic [31:0] want_index;
        logic [31:0] want_dest;
        status_t     want_status;
    } stim_row_t;

    // shadow of the table state and registers
    logic [15:0] sh_keys;
    logic [15:0] sh_bpk;
    logic [23:0] sh_bpb;
    logic [12:0] sh_limit;
    logic [63:0] sh_words [N_WORDS];
    logic [31:0] sh_recent_ix [16];
    logic [31:0] sh_recent_dx [16];
    int unsigned sh_count;
    logic [12:0] sh_spill_key [N_SPILL];
    logic [31:0] sh_spill_val [N_SPILL];
    bit          sh_spill_used [N_SPILL];

    offset_result_t pending_results [$];
    int          fail_count;
    int          status_seen [4];
    int          appends_sent;
    int          queries_sent;

    delta_packed_offset_table i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // run limit
    initial
    begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // dest delta scaled by bits per key, truncated toward zero
    function automatic logic [31:0] key_correction(input logic [31:0] dd);
        logic [31:0]    mag;
        longint unsigned prod;
        mag  = dd[31] ? (32'd0 - dd) : dd;
        prod = ({32'd0, mag} * {48'd0, sh_bpk}) >> 8;
        return dd[31] ? (32'd0 - prod[31:0]) : prod[31:0];
    endfunction

    // word, bit place and width of a non-head entry
    function automatic void delta_place(input int unsigned e, output int unsigned word,
                                        output int unsigned shift, output bit wide);
        int unsigned r;
        int unsigned rank;
        r = e % 16;
        if (r % 4 == 0)
        begin
            word  = (e / 16) * 5 + 1;
            shift = (r / 4 - 1) * 10;
            wide  = 1'b1;
        end
        else
        begin
            rank  = r - r / 4 - 1;
            word  = (e / 16) * 5 + 2 + rank / 4;
            shift = (rank % 4) * 8;
            wide  = 1'b0;
        end
    endfunction

    function automatic bit delta_fits(input logic [31:0] d, input bit wide);
        longint biased;
        biased = longint'($signed(d)) + (wide ? 511 : 127);
        return biased >= 0 && biased < (wide ? 1022 : 254);
    endfunction

    function automatic logic [31:0] spill_lookup(input logic [12:0] key);
        for (int k = 0; k < N_SPILL; k++)
            if (sh_spill_used[k] && sh_spill_key[k] == key)
                return sh_spill_val[k];
        return 32'd0;
    endfunction

    // stored delta of an entry; sel 0 index, 1 dest
    function automatic logic [31:0] stored_delta(input int unsigned e, input int unsigned sel);
        int unsigned w;
        int unsigned sh;
        bit          wide;
        logic [63:0] fld;
        logic [63:0] m;
        delta_place(e, w, sh, wide);
        m   = wide ? 64'h3ff : 64'h0ff;
        fld = (sh_words[w] >> (sh + 32 * sel)) & m;
        if (fld == m)
            return spill_lookup(13'(e * 2 + sel));
        return fld[31:0] - (wide ? 32'd511 : 32'd127);
    endfunction

    // walk back to the group head and rebuild both offsets
    function automatic void rebuild_pair(input int unsigned e, output logic [31:0] ix,
                                         output logic [31:0] dx);
        int unsigned r;
        int unsigned n;
        logic [31:0] pi;
        logic [31:0] pd;
        logic [31:0] dd;
        r = e % 16;
        if (r == 0)
        begin
            ix = sh_words[(e / 16) * 5][31:0];
            dx = sh_words[(e / 16) * 5][63:32];
        end
        else
        begin
            n = (r % 4 == 0) ? 4 : 1;
            rebuild_pair(e - n, pi, pd);
            dd = stored_delta(e, 1);
            dx = pd + dd + n * sh_keys;
            ix = pi + stored_delta(e, 0) + n * sh_bpb + key_correction(dd);
        end
    endfunction

    function automatic void write_field(input int unsigned w, input int unsigned sh,
                                        input bit wide, input logic [31:0] val);
        logic [63:0] m;
        m = wide ? 64'h3ff : 64'h0ff;
        sh_words[w] = (sh_words[w] & ~(m << sh)) | (({32'd0, val} & m) << sh);
    endfunction

    function automatic void spill_store(input logic [12:0] key, input logic [31:0] val);
        for (int k = 0; k < N_SPILL; k++)
            if (!sh_spill_used[k])
            begin
                sh_spill_used[k] = 1'b1;
                sh_spill_key[k]  = key;
                sh_spill_val[k]  = val;
                return;
            end
    endfunction

    function automatic status_t append_pair(input logic [31:0] ix, input logic [31:0] dx);
        int unsigned lim;
        int unsigned e;
        int unsigned r;
        int unsigned n;
        int unsigned prev;
        int unsigned w;
        int unsigned sh;
        bit          wide;
        bit          fit_i;
        bit          fit_d;
        int          need;
        int          free_slots;
        logic [31:0] dd;
        logic [31:0] di;
        lim = ((int'(sh_limit) + 15) / 16) * 16;
        if (lim > N_ENTRIES)
            lim = N_ENTRIES;
        e = sh_count;
        if (e >= lim)
            return ST_TABLE_FULL;
        r = e % 16;
        if (r == 0)
            sh_words[(e / 16) * 5] = {dx, ix};
        else
        begin
            n    = (r % 4 == 0) ? 4 : 1;
            prev = (e - n) % 16;
            dd   = dx - sh_recent_dx[prev] - n * sh_keys;
            di   = ix - sh_recent_ix[prev] - n * sh_bpb - key_correction(dd);
            delta_place(e, w, sh, wide);
            fit_i = delta_fits(di, wide);
            fit_d = delta_fits(dd, wide);
            need  = (fit_i ? 0 : 1) + (fit_d ? 0 : 1);
            free_slots = 0;
            for (int k = 0; k < N_SPILL; k++)
                if (!sh_spill_used[k])
                    free_slots++;
            if (need > free_slots)
                return ST_SPILL_FULL;
            if (fit_i)
                write_field(w, sh, wide, di + (wide ? 32'd511 : 32'd127));
            else
            begin
                spill_store(13'(e * 2), di);
                write_field(w, sh, wide, 32'hffffffff);
            end
            if (fit_d)
                write_field(w, sh + 32, wide, dd + (wide ? 32'd511 : 32'd127));
            else
            begin
                spill_store(13'(e * 2 + 1), dd);
                write_field(w, sh + 32, wide, 32'hffffffff);
            end
        end
        sh_recent_ix[r] = ix;
        sh_recent_dx[r] = dx;
        sh_count = e + 1;
        return ST_OK;
    endfunction

    // expected result of one beat, updating the shadow state
    function automatic offset_result_t predict_beat(input logic mode, input logic [31:0] ix,
                                                    input logic [31:0] dx,
                                                    input logic [11:0] entry);
        offset_result_t res;
        res.index_off = 32'd0;
        res.dest_off  = 32'd0;
        if (mode == MODE_APPEND)
            res.status = append_pair(ix, dx);
        else if (entry >= sh_count)
            res.status = ST_RANGE;
        else
        begin
            rebuild_pair(entry, res.index_off, res.dest_off);
            res.status = ST_OK;
        end
        return res;
    endfunction

    // register write over the config port, idle block only
    task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KEYS:  sh_keys  = val[15:0];
            REG_BPK:   sh_bpk   = val[15:0];
            REG_BPB:   sh_bpb   = val[23:0];
            REG_LIMIT: sh_limit = val[12:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // send one beat; expectation pushed before the beat goes out
    task automatic send_beat(input logic mode, input logic [31:0] ix, input logic [31:0] dx,
                             input logic [11:0] entry, input offset_result_t want);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pending_results.push_back(want);
        if (mode == MODE_APPEND)
            appends_sent++;
        else
            queries_sent++;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'd0, entry, dx, ix};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // delta for a generated append: mostly fitting, some on the edge, some spilled
    function automatic logic [31:0] pick_delta(input bit wide);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 88)
            return wide ? 32'($urandom_range(0, 1021)) - 32'd511
                        : 32'($urandom_range(0, 253)) - 32'd127;
        else if (pick < 94)
            case ($urandom_range(0, 3))
                0: return wide ? 32'd510 : 32'd126;
                1: return wide ? 32'd511 : 32'd127;
                2: return wide ? -32'd511 : -32'd127;
                default: return wide ? -32'd512 : -32'd128;
            endcase
        else
            return $urandom;
    endfunction

    task automatic random_beat();
        int unsigned r;
        int unsigned n;
        int unsigned prev;
        bit          wide;
        logic [31:0] ix;
        logic [31:0] dx;
        logic [31:0] dd;
        logic [11:0] entry;
        offset_result_t want;
        if ($urandom_range(0, 99) < 55)
        begin
            r = sh_count % 16;
            if (r == 0 || $urandom_range(0, 99) < 3)
            begin
                ix = $urandom;
                dx = $urandom;
            end
            else
            begin
                n    = (r % 4 == 0) ? 4 : 1;
                wide = (n == 4);
                prev = (sh_count - n) % 16;
                dd   = pick_delta(wide);
                dx   = sh_recent_dx[prev] + dd + n * sh_keys;
                ix   = sh_recent_ix[prev] + pick_delta(wide) + n * sh_bpb + key_correction(dd);
            end
            entry = 12'($urandom);
            want = predict_beat(MODE_APPEND, ix, dx, entry);
            send_beat(MODE_APPEND, ix, dx, entry, want);
        end
        else
        begin
            if (sh_count == 0 || $urandom_range(0, 99) < 10)
                entry = 12'($urandom);
            else
                entry = 12'($urandom_range(0, sh_count - 1));
            ix = $urandom;
            dx = $urandom;
            want = predict_beat(MODE_QUERY, ix, dx, entry);
            send_beat(MODE_QUERY, ix, dx, entry, want);
        end
    endtask

    // directed rows under reset config (all strides zero)
    stim_row_t directed_rows [] = '{
        '{MODE_QUERY,  32'h0,        32'h0,        12'd0,    1, 32'h0, 32'h0, ST_RANGE},
        '{MODE_QUERY,  32'hffffffff, 32'hffffffff, 12'd4095, 1, 32'h0, 32'h0, ST_RANGE},
        '{MODE_APPEND, 32'hfffffff0, 32'hffffff00, 12'hfff,  1, 32'h0, 32'h0, ST_OK},
        '{MODE_QUERY,  32'h0,        32'h0,        12'd0,    1,
          32'hfffffff0, 32'hffffff00, ST_OK},
        // largest fitting narrow delta and the lowest one
        '{MODE_APPEND, 32'h0000006e, 32'hfffffe81, 12'd0,    1, 32'h0, 32'h0, ST_OK},
        // one past the narrow range on index, far jump on dest: both spill
        '{MODE_APPEND, 32'h000000ed, 32'h7ffffe81, 12'd0,    0, 32'h0, 32'h0, ST_OK},
        // zero delta
        '{MODE_APPEND, 32'h000000ed, 32'h7ffffe81, 12'd0,    0, 32'h0, 32'h0, ST_OK},
        // wide slot from the group head, both ends of its range
        '{MODE_APPEND, 32'h000001ee, 32'hfffffd01, 12'd0,    0, 32'h0, 32'h0, ST_OK},
        // narrow delta one below the range spills
        '{MODE_APPEND, 32'h0000016e, 32'hfffffd81, 12'd0,    0, 32'h0, 32'h0, ST_OK},
        '{MODE_QUERY,  32'h0,        32'h0,        12'd1,    0, 32'h0, 32'h0, ST_OK},
        '{MODE_QUERY,  32'h0,        32'h0,        12'd2,    0, 32'h0, 32'h0, ST_OK},
        '{MODE_QUERY,  32'h0,        32'h0,        12'd3,    0, 32'h0, 32'h0, ST_OK},
        '{MODE_QUERY,  32'h0,        32'h0,        12'd4,    0, 32'h0, 32'h0, ST_OK},
        '{MODE_QUERY,  32'h0,        32'h0,        12'd5,    0, 32'h0, 32'h0, ST_OK},
        '{MODE_QUERY,  32'h0,        32'h0,        12'd6,    1, 32'h0, 32'h0, ST_RANGE}
    };

    // result receiver stalls
    initial
    begin
        int hold;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = idle_len();
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // output beat checker
    always @(posedge clk)
    begin
        offset_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("output beat with no expectation waiting");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                status_seen[m_tdata[65:64]]++;
                if (m_tdata[31:0] !== want.index_off)
                begin
                    $error("index_offset_out: expected %h, got %h", want.index_off,
                           m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== want.dest_off)
                begin
                    $error("dest_offset_out: expected %h, got %h", want.dest_off,
                           m_tdata[63:32]);
                    fail_count++;
                end
                if (m_tdata[65:64] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[65:64]);
                    fail_count++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        offset_result_t want;
        logic [31:0] phase_cfg [5][4];
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        fail_count   = 0;
        appends_sent = 0;
        queries_sent = 0;
        status_seen  = '{0, 0, 0, 0};
        sh_keys  = '0;
        sh_bpk   = '0;
        sh_bpb   = '0;
        sh_limit = 13'd4096;
        sh_count = 0;
        for (int k = 0; k < N_WORDS; k++)
            sh_words[k] = '0;
        for (int k = 0; k < 16; k++)
        begin
            sh_recent_ix[k] = '0;
            sh_recent_dx[k] = '0;
        end
        for (int k = 0; k < N_SPILL; k++)
            sh_spill_used[k] = 1'b0;

        // keys, bits per key, bits per bucket, limit
        phase_cfg[0] = '{32'd100, 32'h0180, 32'd5000, 32'd4096};
        phase_cfg[1] = '{32'hffff, 32'hffff, 32'hffffff, 32'h1fff};
        phase_cfg[2] = '{32'd0, 32'd0, 32'd0, 32'd0};
        phase_cfg[3] = '{$urandom, $urandom_range(0, 1024), $urandom, 32'd4096};
        phase_cfg[4] = '{$urandom_range(0, 300), $urandom_range(0, 600),
                         $urandom_range(0, 100000), 32'd0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
        begin
            want = predict_beat(directed_rows[i].mode, directed_rows[i].index_off,
                                directed_rows[i].dest_off, directed_rows[i].entry);
            if (directed_rows[i].typed)
            begin
                want.index_off = directed_rows[i].want_index;
                want.dest_off  = directed_rows[i].want_dest;
                want.status    = directed_rows[i].want_status;
            end
            send_beat(directed_rows[i].mode, directed_rows[i].index_off,
                      directed_rows[i].dest_off, directed_rows[i].entry, want);
        end
        s_tvalid <= 1'b0;

        // random phases, each under its own register setting
        for (int p = 0; p < 5; p++)
        begin
            drain();
            if (p == 4)
                phase_cfg[p][3] = sh_count + 20;
            reg_write(REG_KEYS,  phase_cfg[p][0]);
            reg_write(REG_BPK,   phase_cfg[p][1]);
            reg_write(REG_BPB,   phase_cfg[p][2]);
            reg_write(REG_LIMIT, phase_cfg[p][3]);
            repeat (PHASE_BEATS) random_beat();
            s_tvalid <= 1'b0;
        end

        drain();
        $display("sent %0d appends and %0d queries over five register settings",
                 appends_sent, queries_sent);
        $display("statuses seen: ok %0d, table full %0d, spill full %0d, out of range %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
